[src/rma_pkg.sv]
`default_nettype none
package rma_pkg;
    localparam int unsigned CMD_BITS = 3;
    localparam logic [CMD_BITS-1:0] CMD_IDENT  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ROTX   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_ROTY   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_ROTZ   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_MULST  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_TRST   = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_MULOUT = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_TROUT  = 3'd7;
    localparam int unsigned ANG_BITS = 32;
    localparam int unsigned ATAN_BITS = 31;
    localparam logic [63:0] GAIN_Q30 = 64'd652032874;

    // Binary-angle arctangent of 2^-i, zero from step 31 on.
    function automatic logic [ATAN_BITS-1:0] atan_lut(input logic [5:0] i);
        logic [ATAN_BITS-1:0] v;
        unique case (i)
            6'd0:  v = 31'd536870912;
            6'd1:  v = 31'd316933406;
            6'd2:  v = 31'd167458907;
            6'd3:  v = 31'd85004756;
            6'd4:  v = 31'd42667331;
            6'd5:  v = 31'd21354465;
            6'd6:  v = 31'd10679838;
            6'd7:  v = 31'd5340245;
            6'd8:  v = 31'd2670163;
            6'd9:  v = 31'd1335087;
            6'd10: v = 31'd667544;
            6'd11: v = 31'd333772;
            6'd12: v = 31'd166886;
            6'd13: v = 31'd83443;
            6'd14: v = 31'd41722;
            6'd15: v = 31'd20861;
            6'd16: v = 31'd10430;
            6'd17: v = 31'd5215;
            6'd18: v = 31'd2608;
            6'd19: v = 31'd1304;
            6'd20: v = 31'd652;
            6'd21: v = 31'd326;
            6'd22: v = 31'd163;
            6'd23: v = 31'd81;
            6'd24: v = 31'd41;
            6'd25: v = 31'd20;
            6'd26: v = 31'd10;
            6'd27: v = 31'd5;
            6'd28: v = 31'd3;
            6'd29: v = 31'd1;
            6'd30: v = 31'd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

[src/rma_if.sv]
`default_nettype none
interface rma_req_if #(
    parameter int unsigned ELEM_BITS = 32
) ();
    logic                        valid;
    logic                        ready;
    logic [rma_pkg::CMD_BITS-1:0] cmd;
    logic signed [rma_pkg::ANG_BITS-1:0] angle;
    logic signed [ELEM_BITS-1:0] rhs_e00, rhs_e01, rhs_e02;
    logic signed [ELEM_BITS-1:0] rhs_e10, rhs_e11, rhs_e12;
    logic signed [ELEM_BITS-1:0] rhs_e20, rhs_e21, rhs_e22;
    modport source (output valid, cmd, angle, rhs_e00, rhs_e01, rhs_e02, rhs_e10,
                    rhs_e11, rhs_e12, rhs_e20, rhs_e21, rhs_e22, input ready);
    modport sink (input valid, cmd, angle, rhs_e00, rhs_e01, rhs_e02, rhs_e10,
                  rhs_e11, rhs_e12, rhs_e20, rhs_e21, rhs_e22, output ready);
endinterface

interface rma_rsp_if #(
    parameter int unsigned ELEM_BITS = 32
) ();
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] out_e00, out_e01, out_e02;
    logic signed [ELEM_BITS-1:0] out_e10, out_e11, out_e12;
    logic signed [ELEM_BITS-1:0] out_e20, out_e21, out_e22;
    logic                        saturated;
    modport source (output valid, out_e00, out_e01, out_e02, out_e10, out_e11,
                    out_e12, out_e20, out_e21, out_e22, saturated, input ready);
    modport sink (input valid, out_e00, out_e01, out_e02, out_e10, out_e11,
                  out_e12, out_e20, out_e21, out_e22, saturated, output ready);
endinterface
`default_nettype wire

[src/rma_cordic.sv]
`default_nettype none
module rma_cordic #(
    parameter int unsigned ELEM_BITS    = 32,
    parameter int unsigned FRAC_BITS    = 28,
    parameter int unsigned CORDIC_STEPS = 28
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rma_pkg::ANG_BITS-1:0]  i_angle,
    output logic                               o_done,
    output logic signed [ELEM_BITS+1:0]        o_cos,
    output logic signed [ELEM_BITS+1:0]        o_sin
);
    localparam int unsigned XW = ELEM_BITS + 2;
    localparam int unsigned ZW = rma_pkg::ANG_BITS + 1;
    localparam int unsigned CW = $clog2(CORDIC_STEPS + 1);
    localparam logic [63:0] GAIN = (FRAC_BITS == 30) ? rma_pkg::GAIN_Q30 :
        (FRAC_BITS < 30) ? ((rma_pkg::GAIN_Q30 + (64'd1 << (29 - FRAC_BITS)))
                            >> (30 - FRAC_BITS)) :
        (rma_pkg::GAIN_Q30 << (FRAC_BITS - 30));

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_flip, r_done;
    logic [rma_pkg::ANG_BITS-1:0] w_ang;
    logic signed [ZW-1:0] w_a;
    logic [5:0]           w_i;
    logic [1:0]           w_q;

    assign w_q   = i_angle[rma_pkg::ANG_BITS-1 -: 2];
    assign w_ang = (w_q == 2'd1 || w_q == 2'd2) ?
                   (i_angle ^ {1'b1, {(rma_pkg::ANG_BITS-1){1'b0}}}) : i_angle;
    assign w_i   = 6'(r_cnt);
    assign w_a   = ZW'(rma_pkg::atan_lut(w_i));

    always_comb begin
        if (!r_z[ZW-1]) begin
            n_x = r_x - (r_y >>> w_i);
            n_y = r_y + (r_x >>> w_i);
            n_z = r_z - w_a;
        end else begin
            n_x = r_x + (r_y >>> w_i);
            n_y = r_y - (r_x >>> w_i);
            n_z = r_z + w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_flip <= (w_q == 2'd1 || w_q == 2'd2);
                r_x    <= XW'(GAIN);
                r_y    <= '0;
                r_z    <= ZW'(signed'(w_ang));
            end else if (r_busy) begin
                if (r_cnt == CW'(CORDIC_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (r_flip) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                end else begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_z   <= n_z;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;
endmodule
`default_nettype wire

[src/rma_lane.sv]
`default_nettype none
// One dot-product lane: three registered products, then round and clip.
module rma_lane #(
    parameter int unsigned ELEM_BITS = 32,
    parameter int unsigned FRAC_BITS = 28
) (
    input  wire logic                        i_clk,
    input  wire logic signed [ELEM_BITS+1:0] i_a0, i_a1, i_a2,
    input  wire logic signed [ELEM_BITS-1:0] i_b0, i_b1, i_b2,
    output logic signed [ELEM_BITS-1:0]      o_res,
    output logic                             o_sat
);
    localparam int unsigned PW = 2 * ELEM_BITS + 2;
    localparam int unsigned SW = PW + 2;

    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    logic signed [SW-1:0] w_sum, w_rnd;
    logic signed [SW-FRAC_BITS-1:0] w_q;
    logic signed [SW-FRAC_BITS-1:0] w_hi, w_lo;

    always_ff @(posedge i_clk) begin
        r_p0 <= PW'(i_a0 * i_b0);
        r_p1 <= PW'(i_a1 * i_b1);
        r_p2 <= PW'(i_a2 * i_b2);
    end

    // Exact sum then one round half up equals the split-sum form.
    assign w_sum = SW'(r_p0) + SW'(r_p1) + SW'(r_p2);
    assign w_rnd = w_sum + (SW'(1) <<< (FRAC_BITS - 1));
    assign w_q   = w_rnd[SW-1:FRAC_BITS];
    assign w_hi  = (SW-FRAC_BITS)'({1'b0, {(ELEM_BITS-1){1'b1}}});
    assign w_lo  = ~w_hi;

    always_comb begin
        o_sat = 1'b0;
        if (w_q > w_hi) begin
            o_res = {1'b0, {(ELEM_BITS-1){1'b1}}};
            o_sat = 1'b1;
        end else if (w_q < w_lo) begin
            o_res = {1'b1, {(ELEM_BITS-1){1'b0}}};
            o_sat = 1'b1;
        end else begin
            o_res = w_q[ELEM_BITS-1:0];
        end
    end
endmodule
`default_nettype wire

[src/rotation_matrix_accumulator_3x3_unit.sv]
`default_nettype none
// Channel  | Dir | Handshake     | Payload
// s_req    | in  | valid / ready | cmd, angle, rhs_e00..rhs_e22
// m_rsp    | out | valid / ready | out_e00..out_e22, saturated
//
// One request at a time. Identity and transpose: output set on acceptance.
// Multiply: product register then round/clip into the output register.
// Rotations: the iterative CORDIC loop first, then the multiply path.
// Reset loads identity. A waiting response holds the next request off
// until it is taken; a new request is taken in the cycle it drains.
module rotation_matrix_accumulator_3x3_unit #(
    parameter int unsigned ELEM_BITS    = 32,
    parameter int unsigned FRAC_BITS    = 28,
    parameter int unsigned CORDIC_STEPS = 28
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rma_req_if.sink   s_req,
    rma_rsp_if.source m_rsp
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int unsigned EW = ELEM_BITS;
    localparam int unsigned XW = ELEM_BITS + 2;

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [XW-1:0] t_wide;

    logic [2:0]  r_state;
    t_elem       r_m [9];
    t_elem       r_o [9];
    t_elem       r_rhs [9];
    logic        r_osat;
    logic [2:0]  r_cmd;
    logic        w_acc, w_cdone, w_store;
    t_wide       w_cos, w_sin;
    t_wide       w_a [9][3];
    t_elem       w_b [9][3];
    t_elem       w_res [9];
    logic [8:0]  w_sat;
    t_elem       w_one;

    assign w_one = (FRAC_BITS >= EW - 1) ? {1'b0, {(EW-1){1'b1}}} :
                   (t_elem'(1) <<< FRAC_BITS);
    assign s_req.ready = (r_state == ST_IDLE) ||
                         (r_state == ST_OUT && m_rsp.ready);
    assign w_acc = s_req.valid && s_req.ready;

    rma_cordic #(.ELEM_BITS(EW), .FRAC_BITS(FRAC_BITS),
                 .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_acc && (s_req.cmd == rma_pkg::CMD_ROTX ||
                           s_req.cmd == rma_pkg::CMD_ROTY ||
                           s_req.cmd == rma_pkg::CMD_ROTZ)),
        .i_angle(s_req.angle), .o_done(w_cdone), .o_cos(w_cos), .o_sin(w_sin)
    );

    // Lane operands: rows p,q rotate as c*p + s*q and -s*p + c*q.
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            for (int k = 0; k < 3; k++) begin
                w_a[e][k] = XW'(r_m[(e/3)*3+k]);
                w_b[e][k] = r_rhs[k*3+(e%3)];
            end
        end
        if (r_cmd != rma_pkg::CMD_MULST && r_cmd != rma_pkg::CMD_MULOUT) begin
            for (int e = 0; e < 9; e++) begin
                w_a[e][0] = w_cos;
                w_a[e][1] = w_sin;
                w_a[e][2] = '0;
                w_b[e][0] = r_m[e];
                w_b[e][1] = '0;
                w_b[e][2] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                unique case (r_cmd)
                    rma_pkg::CMD_ROTX: begin
                        w_b[3+k][1] = r_m[6+k];
                        w_a[6+k][0] = -w_sin; w_a[6+k][1] = w_cos;
                        w_b[6+k][0] = r_m[3+k]; w_b[6+k][1] = r_m[6+k];
                    end
                    rma_pkg::CMD_ROTY: begin
                        w_b[6+k][1] = r_m[k];
                        w_a[k][0] = -w_sin; w_a[k][1] = w_cos;
                        w_b[k][0] = r_m[6+k]; w_b[k][1] = r_m[k];
                    end
                    default: begin
                        w_b[k][1] = r_m[3+k];
                        w_a[3+k][0] = -w_sin; w_a[3+k][1] = w_cos;
                        w_b[3+k][0] = r_m[k]; w_b[3+k][1] = r_m[3+k];
                    end
                endcase
            end
        end
    end

    for (genvar e = 0; e < 9; e++) begin : g_lane
        rma_lane #(.ELEM_BITS(EW), .FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk(i_clk),
            .i_a0(w_a[e][0]), .i_a1(w_a[e][1]), .i_a2(w_a[e][2]),
            .i_b0(w_b[e][0]), .i_b1(w_b[e][1]), .i_b2(w_b[e][2]),
            .o_res(w_res[e]), .o_sat(w_sat[e])
        );
    end

    // Rotations only touch two rows; the untouched row keeps its value.
    function automatic logic row_on(input logic [2:0] c, input int r);
        return (c == rma_pkg::CMD_ROTX) ? (r != 0) :
               (c == rma_pkg::CMD_ROTY) ? (r != 1) :
               (c == rma_pkg::CMD_ROTZ) ? (r != 2) : 1'b1;
    endfunction

    assign w_store = (r_cmd != rma_pkg::CMD_MULOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int e = 0; e < 9; e++)
                r_m[e] <= (e % 4 == 0) ? w_one : '0;
        end else begin
            unique case (r_state)
                ST_IDLE, ST_OUT: begin
                    if (r_state == ST_OUT && m_rsp.ready)
                        r_state <= ST_IDLE;
                    if (w_acc) begin
                        r_cmd <= s_req.cmd;
                        r_rhs <= '{s_req.rhs_e00, s_req.rhs_e01, s_req.rhs_e02,
                                   s_req.rhs_e10, s_req.rhs_e11, s_req.rhs_e12,
                                   s_req.rhs_e20, s_req.rhs_e21, s_req.rhs_e22};
                        unique case (s_req.cmd)
                            rma_pkg::CMD_IDENT: begin
                                for (int e = 0; e < 9; e++) begin
                                    r_m[e] <= (e % 4 == 0) ? w_one : '0;
                                    r_o[e] <= (e % 4 == 0) ? w_one : '0;
                                end
                                r_osat  <= 1'b0;
                                r_state <= ST_OUT;
                            end
                            rma_pkg::CMD_TRST, rma_pkg::CMD_TROUT: begin
                                for (int e = 0; e < 9; e++) begin
                                    r_o[e] <= r_m[(e%3)*3+(e/3)];
                                    if (s_req.cmd == rma_pkg::CMD_TRST)
                                        r_m[e] <= r_m[(e%3)*3+(e/3)];
                                end
                                r_osat  <= 1'b0;
                                r_state <= ST_OUT;
                            end
                            rma_pkg::CMD_MULST, rma_pkg::CMD_MULOUT:
                                r_state <= ST_MUL;
                            default: r_state <= ST_ROT;
                        endcase
                    end
                end
                ST_ROT: if (w_cdone) r_state <= ST_MUL;
                ST_MUL: r_state <= ST_RND;
                ST_RND: begin
                    // Merge the lanes: gather results and OR the clip flags.
                    r_osat <= 1'b0;
                    for (int e = 0; e < 9; e++) begin
                        if (row_on(r_cmd, e / 3)) begin
                            r_o[e] <= w_res[e];
                            if (w_store) r_m[e] <= w_res[e];
                            if (w_sat[e]) r_osat <= 1'b1;
                        end else begin
                            r_o[e] <= r_m[e];
                        end
                    end
                    r_state <= ST_OUT;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_rsp.valid     = (r_state == ST_OUT);
    assign m_rsp.out_e00   = r_o[0];
    assign m_rsp.out_e01   = r_o[1];
    assign m_rsp.out_e02   = r_o[2];
    assign m_rsp.out_e10   = r_o[3];
    assign m_rsp.out_e11   = r_o[4];
    assign m_rsp.out_e12   = r_o[5];
    assign m_rsp.out_e20   = r_o[6];
    assign m_rsp.out_e21   = r_o[7];
    assign m_rsp.out_e22   = r_o[8];
    assign m_rsp.saturated = r_osat;
endmodule
`default_nettype wire

[tb/sv/rotation_matrix_accumulator_3x3_unit_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_accumulator_3x3_unit_test;

    localparam int FRAC = 28;
    localparam int STEPS = 28;
    localparam longint EMAX = 64'sd2147483647;
    localparam longint EMIN = -64'sd2147483648;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [31:0] m [9];
        logic        sat;
    } t_mat_result;

    logic i_clk;
    logic i_rst_n;
    rma_req_if #(.ELEM_BITS(32)) req_ch ();
    rma_rsp_if #(.ELEM_BITS(32)) rsp_ch ();

    rotation_matrix_accumulator_3x3_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_req  (req_ch.sink),
        .m_rsp  (rsp_ch.source)
    );

    // Shadow copy of the stored matrix, Q4.28, held wide.
    longint      shadow [9];
    t_mat_result pending_results [$];
    int          fail_count;
    int          cycle_count;
    logic        drain_gaps;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sum of exact products, rounded once half up, then clipped.
    // Arithmetic shift of a 128-bit sum keeps the rounding exact.
    function automatic longint dot_round(input longint a0, b0, a1, b1, a2, b2,
                                         inout logic flag);
        logic signed [127:0] acc;
        acc = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2);
        acc = acc + (128'sd1 <<< (FRAC - 1));
        acc = acc >>> FRAC;
        if (acc > EMAX) begin
            flag = 1'b1;
            return EMAX;
        end
        if (acc < EMIN) begin
            flag = 1'b1;
            return EMIN;
        end
        return longint'(acc);
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x, y, z, dx, dy, at;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang[31] = ~ang[31];
        z = longint'($signed(ang));
        x = (longint'(rma_pkg::GAIN_Q30) + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            at = longint'(rma_pkg::atan_lut(6'(i)));
            if (z >= 0) begin
                x -= dx; y += dy; z -= at;
            end else begin
                x += dx; y -= dy; z += at;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    // Apply one request to the shadow matrix and queue the expected response.
    task automatic predict_matrix(input logic [2:0] cmd, input logic [31:0] ang,
                                  input logic [31:0] rhs [9]);
        t_mat_result exp_res;
        longint      res [9];
        longint      r [9];
        longint      c, s, a, b;
        longint      np [3], nq [3];
        int          p, q;
        logic        flag;
        flag = 1'b0;
        for (int k = 0; k < 9; k++) r[k] = longint'($signed(rhs[k]));
        case (cmd)
            rma_pkg::CMD_IDENT: begin
                for (int k = 0; k < 9; k++) shadow[k] = (k % 4 == 0) ? ONE : 0;
                res = shadow;
            end
            rma_pkg::CMD_ROTX, rma_pkg::CMD_ROTY, rma_pkg::CMD_ROTZ: begin
                sin_cos(ang, c, s);
                p = (cmd == rma_pkg::CMD_ROTX) ? 1 : (cmd == rma_pkg::CMD_ROTY) ? 2 : 0;
                q = (cmd == rma_pkg::CMD_ROTX) ? 2 : (cmd == rma_pkg::CMD_ROTY) ? 0 : 1;
                for (int k = 0; k < 3; k++) begin
                    a = shadow[p * 3 + k];
                    b = shadow[q * 3 + k];
                    np[k] = dot_round(c, a, s, b, 0, 0, flag);
                    nq[k] = dot_round(-s, a, c, b, 0, 0, flag);
                end
                for (int k = 0; k < 3; k++) begin
                    shadow[p * 3 + k] = np[k];
                    shadow[q * 3 + k] = nq[k];
                end
                res = shadow;
            end
            rma_pkg::CMD_MULST, rma_pkg::CMD_MULOUT: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        res[i * 3 + j] = dot_round(shadow[i * 3], r[j],
                            shadow[i * 3 + 1], r[3 + j], shadow[i * 3 + 2], r[6 + j], flag);
                if (cmd == rma_pkg::CMD_MULST) shadow = res;
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        res[j * 3 + i] = shadow[i * 3 + j];
                if (cmd == rma_pkg::CMD_TRST) shadow = res;
            end
        endcase
        for (int k = 0; k < 9; k++) exp_res.m[k] = res[k][31:0];
        exp_res.sat = flag;
        pending_results.push_back(exp_res);
    endtask

    // Send one request: wait a random gap, hold valid until taken.
    // Drop valid only ahead of an idle gap.
    task automatic send_request(input logic [2:0] cmd, input logic [31:0] ang,
                                input logic [31:0] rhs [9]);
        int gap;
        gap = drain_gaps ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= cmd;
        req_ch.angle   <= ang;
        req_ch.rhs_e00 <= rhs[0];
        req_ch.rhs_e01 <= rhs[1];
        req_ch.rhs_e02 <= rhs[2];
        req_ch.rhs_e10 <= rhs[3];
        req_ch.rhs_e11 <= rhs[4];
        req_ch.rhs_e12 <= rhs[5];
        req_ch.rhs_e20 <= rhs[6];
        req_ch.rhs_e21 <= rhs[7];
        req_ch.rhs_e22 <= rhs[8];
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_matrix(cmd, ang, rhs);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] rhs [9];
        logic [31:0] angs [8];
        angs = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hc000_0000,
                 32'h7fff_ffff, 32'h8000_0001, 32'h2000_0000, 32'hffff_ffff};
        for (int k = 0; k < 9; k++) rhs[k] = (k % 4 == 0) ? 32'(ONE) : 32'h0;
        send_request(rma_pkg::CMD_TRST, 0, rhs);
        send_request(rma_pkg::CMD_TROUT, 0, rhs);
        send_request(rma_pkg::CMD_MULOUT, 0, rhs);
        for (int k = 0; k < 8; k++)
            send_request(3'(rma_pkg::CMD_ROTX + k % 3), angs[k], rhs);
        send_request(rma_pkg::CMD_TRST, 0, rhs);
        send_request(rma_pkg::CMD_TROUT, 0, rhs);
        send_request(rma_pkg::CMD_IDENT, 32'hffff_ffff, rhs);
        // Full-scale operands: products clip at the negative limit.
        for (int k = 0; k < 9; k++) rhs[k] = 32'h7fff_ffff;
        send_request(rma_pkg::CMD_MULOUT, 0, rhs);
        send_request(rma_pkg::CMD_MULST, 0, rhs);
        for (int k = 0; k < 9; k++) rhs[k] = 32'h8000_0000;
        send_request(rma_pkg::CMD_MULST, 0, rhs);
        send_request(rma_pkg::CMD_ROTZ, 32'h1000_0000, rhs);
        send_request(rma_pkg::CMD_TRST, 0, rhs);
        send_request(rma_pkg::CMD_IDENT, 0, rhs);
        for (int k = 0; k < 9; k++) rhs[k] = 32'hffff_ffff;
        send_request(rma_pkg::CMD_MULST, 0, rhs);
        send_request(rma_pkg::CMD_IDENT, 0, rhs);
    endtask

    task automatic test_random();
        logic [31:0] rhs [9];
        logic [2:0]  cmd;
        for (int n = 0; n < 1880; n++) begin
            // Alternate stretches with and without idle gaps.
            if (n % 200 == 0) drain_gaps = ($urandom_range(0, 2) != 0);
            cmd = 3'($urandom_range(0, 7));
            // Reload identity now and then so rotations stay in range.
            if ($urandom_range(0, 15) == 0) cmd = rma_pkg::CMD_IDENT;
            for (int k = 0; k < 9; k++) rhs[k] = rand_elem();
            send_request(cmd, $urandom(), rhs);
        end
    endtask

    // Receiver: random stalls, compare every taken response.
    initial begin
        t_mat_result exp_res;
        logic [31:0] got [9];
        int          stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            got = '{rsp_ch.out_e00, rsp_ch.out_e01, rsp_ch.out_e02,
                    rsp_ch.out_e10, rsp_ch.out_e11, rsp_ch.out_e12,
                    rsp_ch.out_e20, rsp_ch.out_e21, rsp_ch.out_e22};
            if (pending_results.size() == 0) begin
                $display("%0t: response with none expected", $time);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== exp_res.m[k]) begin
                        $display("%0t: element %0d expected %h actual %h",
                                 $time, k, exp_res.m[k], got[k]);
                        fail_count++;
                    end
                if (rsp_ch.saturated !== exp_res.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_res.sat, rsp_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int wait_cycles;
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        fail_count = 0;
        cycle_count = 0;
        drain_gaps = 1'b1;
        req_ch.valid <= 1'b0;
        req_ch.cmd <= rma_pkg::CMD_IDENT;
        req_ch.angle <= '0;
        {req_ch.rhs_e00, req_ch.rhs_e01, req_ch.rhs_e02} <= '0;
        {req_ch.rhs_e10, req_ch.rhs_e11, req_ch.rhs_e12} <= '0;
        {req_ch.rhs_e20, req_ch.rhs_e21, req_ch.rhs_e22} <= '0;
        for (int k = 0; k < 9; k++) shadow[k] = (k % 4 == 0) ? ONE : 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        req_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (STEPS + 10) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

[rotation_matrix_accumulator_3x3_unit.f]
src/rma_pkg.sv
src/rma_if.sv
src/rma_cordic.sv
src/rma_lane.sv
src/rotation_matrix_accumulator_3x3_unit.sv
tb/sv/rotation_matrix_accumulator_3x3_unit_test.sv
